>>> design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

>>> design/stp_pkg.sv
package stp_pkg;

   localparam int SLOT_COUNT_DEFAULT = 16;
   localparam int MAX_EVENTS         = 16;
   localparam int EVT_CNT_W          = $clog2(MAX_EVENTS + 1);

   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_ALLOC    = 3'd1;
   localparam logic [2:0] OP_START    = 3'd2;
   localparam logic [2:0] OP_SET_PER  = 3'd3;
   localparam logic [2:0] OP_RELEASE  = 3'd4;
   localparam logic [2:0] OP_QUERY    = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_PARAM = 2'd1;
   localparam logic [1:0] ST_BAD_STATE = 2'd2;
   localparam logic [1:0] ST_NO_FREE   = 2'd3;

   localparam logic [1:0] MODE_UNUSED  = 2'd0;
   localparam logic [1:0] MODE_STOPPED = 2'd1;
   localparam logic [1:0] MODE_RUNNING = 2'd2;
   localparam logic [1:0] MODE_EXPIRED = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic        rearm;
      logic        polled;
      logic [31:0] start;
      logic [31:0] period;
   } slot_entry_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] slot;
      logic [1:0] state;
      logic       expiry;
      logic       last;
   } rsp_type;

   function automatic rsp_type make_rsp(logic [1:0] status, logic [3:0] slot,
                                        logic [1:0] state, logic expiry,
                                        logic last);
      rsp_type r;
      r.status = status;
      r.slot   = slot;
      r.state  = state;
      r.expiry = expiry;
      r.last   = last;
      return r;
   endfunction

endpackage

>>> design/software_timer_pool_unit.sv
// Channel  | Ports                        | Handshake
// ---------+------------------------------+------------------------------------
// request  | req_* word                   | taken when start && !busy
// response | rsp_* word                   | rsp_strobe high for one cycle
//
// A tick reads one slot a cycle on the single read port, writes back each
// expiring slot from the registered read, then sends the held event as the
// last word. Allocate checks one used bit a cycle. Start, set period and
// release read, then update; query reads; rejected words answer straight from idle.
// Reset clears the tick counter and the in-use bits; the receiver cannot stall.
`include "assert_macros.svh"

module software_timer_pool_unit #(
   parameter int SLOT_COUNT = stp_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_slot_id,
   input  logic [31:0] req_period_ms,
   input  logic        req_is_polled,
   input  logic        req_auto_restart,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_result_slot,
   output logic [1:0]  rsp_slot_state,
   output logic        rsp_is_expiry_event,
   output logic        rsp_last_result
);

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int EW = stp_pkg::EVT_CNT_W;

   typedef enum logic [1:0] {S_IDLE, S_ALLOC, S_EXEC, S_TICK} state_type;

   state_type                  state_ff, state_in;
   logic [31:0]                tick_ff, tick_in;
   logic [SLOT_COUNT-1:0]      used_ff, used_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic                       ev_vld_ff, ev_vld_in;
   logic [SW-1:0]              ev_idx_ff, ev_idx_in;
   logic                       hold_vld_ff, hold_vld_in;
   logic [3:0]                 hold_slot_ff, hold_slot_in;
   logic [1:0]                 hold_mode_ff, hold_mode_in;
   logic [EW-1:0]              evt_cnt_ff, evt_cnt_in;
   logic [2:0]                 op_ff, op_in;
   logic [3:0]                 id_ff, id_in;
   logic [31:0]                per_ff, per_in;
   logic                       polled_ff, polled_in;
   logic                       rearm_ff, rearm_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   stp_pkg::rsp_type           rsp_ff, rsp_in;

   logic                       wr_en;
   logic [SW-1:0]              wr_addr;
   stp_pkg::slot_entry_type    wr_data;
   logic [SW-1:0]              rd_addr;
   stp_pkg::slot_entry_type    rd_data;

   // Per-item decode helpers.
   logic [SW-1:0]              id_sw;
   logic                       cur_used;
   logic [1:0]                 cur_mode;
   logic                       scan_more;
   logic [31:0]                elapsed;
   logic                       expire;
   stp_pkg::slot_entry_type    upd;

   stp_slot_ram #(
      .SLOT_COUNT (SLOT_COUNT),
      .SW         (SW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read the addressed slot in the accept cycle; during a tick, read the scan index.
   assign rd_addr  = (state_ff == S_TICK) ? idx_ff[SW-1:0] : SW'(req_slot_id);
   assign id_sw    = SW'(id_ff);
   assign cur_used = used_ff[id_sw];
   assign cur_mode = cur_used ? rd_data.mode : stp_pkg::MODE_UNUSED;

   // Tick evaluation runs on the slot read in the previous cycle.
   assign scan_more = (idx_ff != CW'(SLOT_COUNT));
   assign elapsed   = tick_ff - rd_data.start;
   assign expire    = ev_vld_ff && used_ff[ev_idx_ff] && rd_data.polled &&
                      (rd_data.mode == stp_pkg::MODE_RUNNING) &&
                      (elapsed >= rd_data.period);

   always_comb begin
      upd = rd_data;
      if (rd_data.rearm) begin
         upd.start = rd_data.start + rd_data.period;
         upd.mode  = stp_pkg::MODE_RUNNING;
      end else begin
         upd.mode  = stp_pkg::MODE_EXPIRED;
      end
   end

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      ev_vld_in     = 1'b0;
      ev_idx_in     = ev_idx_ff;
      hold_vld_in   = hold_vld_ff;
      hold_slot_in  = hold_slot_ff;
      hold_mode_in  = hold_mode_ff;
      evt_cnt_in    = evt_cnt_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      per_in        = per_ff;
      polled_in     = polled_ff;
      rearm_in      = rearm_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = id_sw;
      wr_data       = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_opcode;
               id_in     = req_slot_id;
               per_in    = req_period_ms;
               polled_in = req_is_polled;
               rearm_in  = req_auto_restart;
               priority if (req_opcode == stp_pkg::OP_TICK) begin
                  // Advance time first; the scan sees the new count.
                  tick_in     = tick_ff + 32'd1;
                  idx_in      = '0;
                  hold_vld_in = 1'b0;
                  evt_cnt_in  = '0;
                  state_in    = S_TICK;
               end else if (req_opcode == stp_pkg::OP_ALLOC) begin
                  idx_in   = '0;
                  state_in = S_ALLOC;
               end else if (req_opcode > stp_pkg::OP_QUERY) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = stp_pkg::make_rsp(stp_pkg::ST_BAD_PARAM, 4'd0,
                                             stp_pkg::MODE_UNUSED, 1'b0, 1'b1);
               end else if ({3'b000, req_slot_id} >= 7'(SLOT_COUNT)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = stp_pkg::make_rsp(stp_pkg::ST_BAD_PARAM, req_slot_id,
                                             stp_pkg::MODE_UNUSED, 1'b0, 1'b1);
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_ALLOC: begin
            // Walk the in-use bits from slot zero; take the first free one.
            priority if (!scan_more) begin
               rsp_strobe_in = 1'b1;
               rsp_in = stp_pkg::make_rsp(stp_pkg::ST_NO_FREE, 4'd0,
                                          stp_pkg::MODE_UNUSED, 1'b0, 1'b1);
               state_in = S_IDLE;
            end else if (!used_ff[idx_ff[SW-1:0]]) begin
               wr_en          = 1'b1;
               wr_addr        = idx_ff[SW-1:0];
               wr_data.period = per_ff;
               wr_data.start  = tick_ff;
               wr_data.polled = polled_ff;
               wr_data.rearm  = rearm_ff;
               wr_data.mode   = (per_ff == 32'd0) ? stp_pkg::MODE_STOPPED
                                                  : stp_pkg::MODE_RUNNING;
               used_in[idx_ff[SW-1:0]] = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_in = stp_pkg::make_rsp(stp_pkg::ST_OK, 4'(idx_ff), wr_data.mode,
                                          1'b0, 1'b1);
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end

         S_EXEC: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            unique case (op_ff)
               stp_pkg::OP_START: begin
                  if (!cur_used) begin
                     rsp_in = stp_pkg::make_rsp(stp_pkg::ST_BAD_STATE, id_ff,
                                                stp_pkg::MODE_UNUSED, 1'b0, 1'b1);
                  end else begin
                     wr_en          = 1'b1;
                     wr_data.period = per_ff;
                     if (per_ff == 32'd0) begin
                        wr_data.mode = stp_pkg::MODE_STOPPED;
                     end else begin
                        wr_data.start = tick_ff;
                        wr_data.mode  = stp_pkg::MODE_RUNNING;
                     end
                     rsp_in = stp_pkg::make_rsp(stp_pkg::ST_OK, id_ff, wr_data.mode,
                                                1'b0, 1'b1);
                  end
               end
               stp_pkg::OP_SET_PER: begin
                  if (per_ff == 32'd0) begin
                     rsp_in = stp_pkg::make_rsp(stp_pkg::ST_BAD_PARAM, id_ff, cur_mode,
                                                1'b0, 1'b1);
                  end else begin
                     wr_en          = 1'b1;
                     wr_data.period = per_ff;
                     rsp_in = stp_pkg::make_rsp(stp_pkg::ST_OK, id_ff, cur_mode,
                                                1'b0, 1'b1);
                  end
               end
               stp_pkg::OP_RELEASE: begin
                  used_in[id_sw] = 1'b0;
                  rsp_in = stp_pkg::make_rsp(stp_pkg::ST_OK, id_ff,
                                             stp_pkg::MODE_UNUSED, 1'b0, 1'b1);
               end
               stp_pkg::OP_QUERY: begin
                  rsp_in = stp_pkg::make_rsp(stp_pkg::ST_OK, id_ff, cur_mode,
                                             1'b0, 1'b1);
               end
               default: begin
                  rsp_in = stp_pkg::make_rsp(stp_pkg::ST_BAD_PARAM, 4'd0,
                                             stp_pkg::MODE_UNUSED, 1'b0, 1'b1);
               end
            endcase
         end

         S_TICK: begin
            // Issue the next read.
            if (scan_more) begin
               ev_vld_in = 1'b1;
               ev_idx_in = idx_ff[SW-1:0];
               idx_in    = idx_ff + CW'(1);
            end
            // Update an expiring slot; keep one event held back so the last
            // one can carry the final flag.
            if (expire) begin
               wr_en   = 1'b1;
               wr_addr = ev_idx_ff;
               wr_data = upd;
               if (evt_cnt_ff < EW'(stp_pkg::MAX_EVENTS)) begin
                  if (hold_vld_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in = stp_pkg::make_rsp(stp_pkg::ST_OK, hold_slot_ff,
                                                hold_mode_ff, 1'b1, 1'b0);
                  end
                  hold_vld_in  = 1'b1;
                  hold_slot_in = 4'(ev_idx_ff);
                  hold_mode_in = upd.mode;
                  evt_cnt_in   = evt_cnt_ff + EW'(1);
               end
            end
            // Scan done: release the held event as the final word.
            if (!scan_more && !ev_vld_ff) begin
               state_in = S_IDLE;
               if (hold_vld_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = stp_pkg::make_rsp(stp_pkg::ST_OK, hold_slot_ff,
                                             hold_mode_ff, 1'b1, 1'b1);
                  hold_vld_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tick_ff       <= 32'd0;
         used_ff       <= '0;
         idx_ff        <= '0;
         ev_vld_ff     <= 1'b0;
         hold_vld_ff   <= 1'b0;
         evt_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         used_ff       <= used_in;
         idx_ff        <= idx_in;
         ev_vld_ff     <= ev_vld_in;
         hold_vld_ff   <= hold_vld_in;
         evt_cnt_ff    <= evt_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ev_idx_ff    <= ev_idx_in;
      hold_slot_ff <= hold_slot_in;
      hold_mode_ff <= hold_mode_in;
      op_ff        <= op_in;
      id_ff        <= id_in;
      per_ff       <= per_in;
      polled_ff    <= polled_in;
      rearm_ff     <= rearm_in;
      rsp_ff       <= rsp_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_result_slot     = rsp_ff.slot;
   assign rsp_slot_state      = rsp_ff.state;
   assign rsp_is_expiry_event = rsp_ff.expiry;
   assign rsp_last_result     = rsp_ff.last;

   // An accepted word either answers at once or keeps the unit busy.
   `ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_strobe || busy)
   // Expiry events are always ok and leave the slot running or expired.
   `ASSERT_SAME(a_event_shape, clock, reset, rsp_strobe && rsp_is_expiry_event,
                rsp_status == stp_pkg::ST_OK &&
                (rsp_slot_state == stp_pkg::MODE_RUNNING ||
                 rsp_slot_state == stp_pkg::MODE_EXPIRED))
   // Command answers are single words.
   `ASSERT_SAME(a_cmd_single, clock, reset, rsp_strobe && !rsp_is_expiry_event,
                rsp_last_result)
   // A held event is always counted, and the count never passes the cap.
   `ASSERT_SAME(a_evt_count, clock, reset, hold_vld_ff,
                evt_cnt_ff != '0 && evt_cnt_ff <= EW'(stp_pkg::MAX_EVENTS))

endmodule

>>> design/stp_slot_ram.sv
module stp_slot_ram #(
   parameter int SLOT_COUNT = stp_pkg::SLOT_COUNT_DEFAULT,
   parameter int SW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [SW-1:0]           wr_addr,
   input  stp_pkg::slot_entry_type wr_data,
   input  logic [SW-1:0]           rd_addr,
   output stp_pkg::slot_entry_type rd_data
);

   stp_pkg::slot_entry_type mem [SLOT_COUNT];
   stp_pkg::slot_entry_type rd_data_ff;

   // Read returns the contents before a same-edge write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
